>>> design/oft_pkg.sv
// ----------------------------------------------------------------------------
// oft_pkg
// Shared types and constants of the optical-flow frame tracker.
// ----------------------------------------------------------------------------
package oft_pkg;

    // History window depth and its derived index width
    localparam int HISTORY_DEPTH = 10;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int VEL_W = 28;

    // Result event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_FRESH = 2'd1;
    localparam logic [1:0] EV_STALE = 2'd2;
    localparam logic [1:0] EV_DECAY = 2'd3;

    // Configuration register indexes
    localparam logic [3:0] REG_FRESH_WINDOW = 4'd0;
    localparam logic [3:0] REG_QUAL_THRESH  = 4'd1;
    localparam logic [3:0] REG_DECAY_TMO    = 4'd2;
    localparam logic [3:0] REG_HEIGHT_OFS   = 4'd3;

    // History write request from the tracker core
    typedef struct packed {
        logic             en;
        logic [VEL_W-1:0] vx;
        logic [VEL_W-1:0] vy;
    } hist_wr_t;

    // Entry about to be overwritten by the next write
    typedef struct packed {
        logic [VEL_W-1:0] vx;
        logic [VEL_W-1:0] vy;
    } hist_rd_t;

endpackage

>>> design/oft_history.sv
// ----------------------------------------------------------------------------
// oft_history
// Circular velocity history in a synchronous RAM. The entry at the next
// slot is prefetched every cycle so it is ready when a fresh frame lands.
// ----------------------------------------------------------------------------
module oft_history (
    input  logic              clk,
    input  logic              rst_n,
    input  oft_pkg::hist_wr_t wr,
    output oft_pkg::hist_rd_t rd
);

    localparam int AW = oft_pkg::HIST_AW;
    localparam int DW = 2 * oft_pkg::VEL_W;
    localparam logic [AW-1:0] LAST = AW'(oft_pkg::HISTORY_DEPTH - 1);

    logic [DW-1:0] mem [oft_pkg::HISTORY_DEPTH];
    logic [oft_pkg::HISTORY_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] slot;
    logic [DW-1:0] rd_data_reg;
    logic          rd_valid_reg;

    // next slot after the pointer, wrapping at the depth
    assign slot = (ptr_reg == LAST) ? '0 : ptr_reg + AW'(1);

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (wr.en)
        begin
            valid_next[slot] = 1'b1;
            ptr_next         = slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            ptr_reg      <= ptr_next;
            rd_valid_reg <= valid_reg[slot];
        end
    end

    // RAM: one write port, one registered read port. Frames are nine items
    // apart, so the prefetch has settled long before the next write.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[slot] <= {wr.vx, wr.vy};
        end
        rd_data_reg <= mem[slot];
    end

    // never-written entries read as zero
    assign rd.vx = rd_valid_reg ? rd_data_reg[DW-1:oft_pkg::VEL_W] : '0;
    assign rd.vy = rd_valid_reg ? rd_data_reg[oft_pkg::VEL_W-1:0] : '0;

endmodule

>>> design/optical_flow_frame_tracker_top.sv
// ----------------------------------------------------------------------------
// optical_flow_frame_tracker_top
// Optical-flow frame parser, velocity scaler and position accumulator.
// ----------------------------------------------------------------------------
// Takes one item per clock: a received byte or a time check. Every accepted
// item yields exactly one result item, registered and shown on the next
// cycle; a new item is taken as long as the result is not stalled. The
// velocity multiply and the divide-by-five of the decay step (a reciprocal
// multiply) are combinational; the history entry to be replaced is prefetched
// from the RAM, so a fresh frame does not stall the input. The history reads
// as zero after reset without a clearing pass.
module optical_flow_frame_tracker_top (
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [7:0]         rx_byte,
    input  logic [31:0]        now_us,
    input  logic [11:0]        height_mm,
    // result items
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_res,
    output logic signed [27:0] vel_x,
    output logic signed [27:0] vel_y,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,
    output logic signed [15:0] quality,
    output logic [39:0]        quality_sum,
    output logic [31:0]        sample_count,
    output logic signed [31:0] window_sum_x,
    output logic signed [31:0] window_sum_y,
    output logic [7:0]         raw_t,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [7:0] HEADER  = 8'hFE;
    localparam logic [7:0] TRAILER = 8'hAA;
    localparam logic [3:0] POS_LAST = 4'd8;

    // configuration
    logic [31:0] fresh_win_reg, decay_tmo_reg;
    logic [7:0]  q_thresh_reg;
    logic [11:0] h_ofs_reg;

    // parser and tracker state
    logic [3:0]  fpos_reg, fpos_next;
    logic [15:0] xp_reg, xp_next, yp_reg, yp_next;
    logic [7:0]  t_held_reg, t_held_next, q_held_reg, q_held_next;
    logic [31:0] last_samp_reg, last_samp_next, last_upd_reg, last_upd_next;
    logic signed [27:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [47:0] px_reg, px_next, py_reg, py_next;
    logic signed [15:0] q_reg, q_next;
    logic [39:0] qsum_reg, qsum_next;
    logic [31:0] cnt_reg, cnt_next;
    logic signed [31:0] wsx_reg, wsx_next, wsy_reg, wsy_next;
    logic [7:0]  lt_reg, lt_next;
    logic [1:0]  ev_reg, ev_next;
    logic        ov_reg, ov_next;

    logic accept;
    oft_pkg::hist_wr_t hwr;
    oft_pkg::hist_rd_t hrd;

    // frame arithmetic
    logic [12:0] h_diff;
    logic [11:0] h_eff;
    logic signed [29:0] mx, my;
    logic [31:0] age_samp, age_upd;
    logic fresh;

    assign in_stall  = ov_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // v * 4 / 5 truncated toward zero, via reciprocal multiply
    function automatic logic signed [27:0] decay_vel(input logic signed [27:0] v);
        logic signed [29:0] v4;
        logic [31:0] mag;
        logic [63:0] prod;
        logic [29:0] quo;
        logic [29:0] res;
        v4   = {v, 2'b00};
        mag  = v4[29] ? 32'(-v4) : 32'(v4);
        mag[31:30] = 2'b00;
        prod = mag * 64'h0000_0000_CCCC_CCCD;
        quo  = prod[63:34];
        res  = v4[29] ? -quo : quo;
        return res[27:0];
    endfunction

    oft_history u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (hwr),
        .rd    (hrd)
    );

    // effective height and velocity products
    assign h_diff   = {1'b0, height_mm} - {1'b0, h_ofs_reg};
    assign h_eff    = h_diff[12] ? 12'd0 : h_diff[11:0];
    assign mx       = $signed(xp_reg) * $signed({2'b00, h_eff});
    assign my       = $signed(yp_reg) * $signed({2'b00, h_eff});
    assign age_samp = now_us - last_samp_reg;
    assign age_upd  = now_us - last_upd_reg;
    assign fresh    = (age_samp < fresh_win_reg) && (q_held_reg > q_thresh_reg);

    // item processing
    always_comb
    begin
        fpos_next      = fpos_reg;
        xp_next        = xp_reg;
        yp_next        = yp_reg;
        t_held_next    = t_held_reg;
        q_held_next    = q_held_reg;
        last_samp_next = last_samp_reg;
        last_upd_next  = last_upd_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        q_next         = q_reg;
        qsum_next      = qsum_reg;
        cnt_next       = cnt_reg;
        wsx_next       = wsx_reg;
        wsy_next       = wsy_reg;
        lt_next        = lt_reg;
        ev_next        = oft_pkg::EV_NONE;
        hwr.en         = 1'b0;
        hwr.vx         = mx[27:0];
        hwr.vy         = my[27:0];

        if (accept && operation)
        begin
            // time check: decay after idle timeout
            if (age_upd > decay_tmo_reg)
            begin
                last_upd_next = now_us;
                vx_next       = decay_vel(vx_reg);
                vy_next       = decay_vel(vy_reg);
                q_next        = (q_reg < -16'sd32766) ? -16'sd32768 : q_reg - 16'sd2;
                ev_next       = oft_pkg::EV_DECAY;
            end
        end
        else if (accept)
        begin
            fpos_next = fpos_reg + 4'd1;
            case (fpos_reg)
                4'd0: fpos_next = (rx_byte == HEADER) ? 4'd1 : 4'd0;
                4'd1: ;
                4'd2: xp_next = {8'h00, rx_byte};
                4'd3: xp_next = {rx_byte, xp_reg[7:0]};
                4'd4: yp_next = {8'h00, rx_byte};
                4'd5: yp_next = {rx_byte, yp_reg[7:0]};
                4'd6: t_held_next = rx_byte[7] ? 8'(9'd256 - {1'b0, rx_byte}) : rx_byte;
                4'd7: q_held_next = rx_byte;
                POS_LAST:
                begin
                    fpos_next = 4'd0;
                    if (rx_byte == TRAILER)
                    begin
                        vx_next        = mx[27:0];
                        vy_next        = my[27:0];
                        q_next         = $signed({8'h00, q_held_reg});
                        lt_next        = t_held_reg;
                        last_samp_next = now_us;
                        last_upd_next  = now_us;
                        ev_next        = oft_pkg::EV_STALE;
                        if (fresh)
                        begin
                            ev_next   = oft_pkg::EV_FRESH;
                            px_next   = px_reg + 48'($signed(mx[27:0]));
                            py_next   = py_reg + 48'($signed(my[27:0]));
                            qsum_next = qsum_reg + {32'h0, q_held_reg};
                            cnt_next  = cnt_reg + 32'd1;
                            wsx_next  = wsx_reg + 32'($signed(mx[27:0]))
                                        - 32'($signed(hrd.vx));
                            wsy_next  = wsy_reg + 32'($signed(my[27:0]))
                                        - 32'($signed(hrd.vy));
                            hwr.en    = 1'b1;
                        end
                    end
                end
                default: fpos_next = 4'd0;
            endcase
        end
    end

    // result register valid
    always_comb
    begin
        ov_next = ov_reg && out_stall;
        if (accept)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpos_reg      <= '0;
            xp_reg        <= '0;
            yp_reg        <= '0;
            t_held_reg    <= '0;
            q_held_reg    <= '0;
            last_samp_reg <= '0;
            last_upd_reg  <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            q_reg         <= '0;
            qsum_reg      <= '0;
            cnt_reg       <= '0;
            wsx_reg       <= '0;
            wsy_reg       <= '0;
            lt_reg        <= '0;
            ev_reg        <= oft_pkg::EV_NONE;
            ov_reg        <= 1'b0;
        end
        else
        begin
            fpos_reg      <= fpos_next;
            xp_reg        <= xp_next;
            yp_reg        <= yp_next;
            t_held_reg    <= t_held_next;
            q_held_reg    <= q_held_next;
            last_samp_reg <= last_samp_next;
            last_upd_reg  <= last_upd_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            q_reg         <= q_next;
            qsum_reg      <= qsum_next;
            cnt_reg       <= cnt_next;
            wsx_reg       <= wsx_next;
            wsy_reg       <= wsy_next;
            lt_reg        <= lt_next;
            if (accept)
            begin
                ev_reg <= ev_next;
            end
            ov_reg        <= ov_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_win_reg <= 32'd50000;
            q_thresh_reg  <= 8'd70;
            decay_tmo_reg <= 32'd50000;
            h_ofs_reg     <= 12'd40;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                oft_pkg::REG_FRESH_WINDOW: fresh_win_reg <= cfg_data;
                oft_pkg::REG_QUAL_THRESH:  q_thresh_reg  <= cfg_data[7:0];
                oft_pkg::REG_DECAY_TMO:    decay_tmo_reg <= cfg_data;
                oft_pkg::REG_HEIGHT_OFS:   h_ofs_reg     <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // state changes only on accept, so it doubles as the result payload
    assign out_valid    = ov_reg;
    assign event_res    = ev_reg;
    assign vel_x        = vx_reg;
    assign vel_y        = vy_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign quality      = q_reg;
    assign quality_sum  = qsum_reg;
    assign sample_count = cnt_reg;
    assign window_sum_x = wsx_reg;
    assign window_sum_y = wsy_reg;
    assign raw_t        = lt_reg;

endmodule

>>> design/oft_checker.sv
// ----------------------------------------------------------------------------
// oft_checker
// Port-level checks of the frame tracker's item flow.
// ----------------------------------------------------------------------------
module oft_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sample_count,
    input logic [1:0]  event_res
);

    // a held result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_count) && $stable(event_res))
        else $error("stalled result changed");

    // input side only stalls behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

    // every accepted item yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item gave no result");

endmodule

bind optical_flow_frame_tracker_top oft_checker u_oft_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_count (sample_count),
    .event_res    (event_res)
);

>>> tb/optical_flow_frame_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optical_flow_frame_tracker_top_tb
// Self-checking bench: drives bytes, time checks and register writes, predicts every result
// item with a behavioral tracker model and compares it field by field.
// ----------------------------------------------------------------------------
module optical_flow_frame_tracker_top_tb;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TIME = 1'b1;
    localparam logic [7:0] HDR_BYTE = 8'hFE;
    localparam logic [7:0] TRL_BYTE = 8'hAA;

    typedef struct packed {
        logic [1:0]         ev;
        logic signed [27:0] vx;
        logic signed [27:0] vy;
        logic [47:0]        px;
        logic [47:0]        py;
        logic signed [15:0] q;
        logic [39:0]        qsum;
        logic [31:0]        cnt;
        logic [31:0]        wsx;
        logic [31:0]        wsy;
        logic [7:0]         t;
    } track_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, in_stall;
    logic operation = 1'b0;
    logic [7:0] rx_byte = '0;
    logic [31:0] now_us = '0;
    logic [11:0] height_mm = '0;
    logic out_valid, out_stall = 1'b0;
    logic [1:0] event_res;
    logic signed [27:0] vel_x, vel_y;
    logic signed [47:0] pos_x, pos_y;
    logic signed [15:0] quality;
    logic [39:0] quality_sum;
    logic [31:0] sample_count;
    logic signed [31:0] window_sum_x, window_sum_y;
    logic [7:0] raw_t;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    optical_flow_frame_tracker_top u_dut (.*);

    // Predictor state
    logic [31:0] fresh_win, decay_tmo;
    logic [7:0]  q_thresh;
    logic [11:0] h_ofs;
    int unsigned fpos;
    logic [15:0] xs, ys;
    logic [7:0]  th, qh, lt;
    logic [31:0] t_sample, t_update;
    logic signed [27:0] vel[2];
    logic [47:0] pos[2];
    logic signed [15:0] qreg;
    logic [39:0] qacc;
    logic [31:0] nsamp;
    logic signed [27:0] hx[oft_pkg::HISTORY_DEPTH], hy[oft_pkg::HISTORY_DEPTH];
    int unsigned hptr;
    logic [31:0] wsum[2];

    track_res_t expected_q[$];
    int errors = 0;
    bit no_idle = 0;
    logic [31:0] clock_us = '0;

    initial forever #6 clk = ~clk;

    initial begin
        #200ms;
        $display("optical_flow_frame_tracker_top verification failed");
        $finish;
    end

    task automatic tracker_reset();
        fresh_win = 32'd50000; q_thresh = 8'd70; decay_tmo = 32'd50000; h_ofs = 12'd40;
        fpos = 0; xs = '0; ys = '0; th = '0; qh = '0; lt = '0;
        t_sample = '0; t_update = '0; vel[0] = '0; vel[1] = '0;
        pos[0] = '0; pos[1] = '0; qreg = '0; qacc = '0; nsamp = '0;
        hptr = 0; wsum[0] = '0; wsum[1] = '0;
        for (int i = 0; i < oft_pkg::HISTORY_DEPTH; i++) begin
            hx[i] = '0; hy[i] = '0;
        end
    endtask

    // Frame completion: scale, then accumulate when fresh
    function automatic logic [1:0] finish_frame(logic [31:0] now, logic [11:0] h);
        int signed he;
        bit fresh;
        logic [31:0] d;
        he = int'(h) - int'(h_ofs);
        if (he < 0) he = 0;
        d = now - t_sample;
        fresh = (d < fresh_win) && (qh > q_thresh);
        vel[0] = 28'($signed(xs) * he);
        vel[1] = 28'($signed(ys) * he);
        if (fresh) begin
            pos[0] = pos[0] + 48'(vel[0]);
            pos[1] = pos[1] + 48'(vel[1]);
            qacc = qacc + 40'(qh);
            nsamp = nsamp + 32'd1;
            hptr = (hptr + 1) % oft_pkg::HISTORY_DEPTH;
            wsum[0] = wsum[0] + 32'(vel[0]) - 32'(hx[hptr]);
            wsum[1] = wsum[1] + 32'(vel[1]) - 32'(hy[hptr]);
            hx[hptr] = vel[0];
            hy[hptr] = vel[1];
        end
        qreg = 16'(qh);
        lt = th;
        t_sample = now;
        t_update = now;
        return fresh ? oft_pkg::EV_FRESH : oft_pkg::EV_STALE;
    endfunction

    function automatic track_res_t tracker_step(logic op, logic [7:0] c,
                                                logic [31:0] now, logic [11:0] h);
        track_res_t r;
        logic [1:0] ev;
        logic [31:0] d;
        ev = oft_pkg::EV_NONE;
        if (op == OP_TIME) begin
            d = now - t_update;
            if (d > decay_tmo) begin
                t_update = now;
                vel[0] = 28'((32'sd4 * vel[0]) / 5);
                vel[1] = 28'((32'sd4 * vel[1]) / 5);
                qreg = (qreg < -16'sd32766) ? -16'sd32768 : qreg - 16'sd2;
                ev = oft_pkg::EV_DECAY;
            end
        end else begin
            case (fpos)
                0: fpos = (c == HDR_BYTE) ? 1 : 0;
                2: xs[7:0] = c;
                3: xs[15:8] = c;
                4: ys[7:0] = c;
                5: ys[15:8] = c;
                6: th = (c > 8'd127) ? 8'(9'd256 - c) : c;
                7: qh = c;
                8: begin
                    if (c == TRL_BYTE) ev = finish_frame(now, h);
                    fpos = 0;
                end
                default: ;
            endcase
        end
        r.ev = ev; r.vx = vel[0]; r.vy = vel[1]; r.px = pos[0]; r.py = pos[1];
        r.q = qreg; r.qsum = qacc; r.cnt = nsamp; r.wsx = wsum[0];
        r.wsy = wsum[1]; r.t = lt;
        return r;
    endfunction

    // Frame position advance kept apart so header handling stays clear
    function automatic void advance_pos(logic op, int unsigned was);
        if (op == OP_BYTE && was >= 1 && was <= 7) fpos = was + 1;
    endfunction

    // Idle burst between items; valid drops only while idling
    task automatic wait_gap();
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Send one item and record its prediction
    task automatic send_item(logic op, logic [7:0] c, logic [31:0] now, logic [11:0] h);
        int unsigned was;
        wait_gap();
        in_valid <= 1'b1; operation <= op; rx_byte <= c;
        now_us <= now; height_mm <= h;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        was = fpos;
        expected_q.push_back(tracker_step(op, c, now, h));
        advance_pos(op, was);
    endtask

    task automatic send_byte(logic [7:0] c, logic [11:0] h = 12'd500);
        clock_us = clock_us + $urandom_range(0, 3000);
        send_item(OP_BYTE, c, clock_us, h);
    endtask

    task automatic send_frame(logic [15:0] x, logic [15:0] y, logic [7:0] t,
                              logic [7:0] q, logic [11:0] h, logic [7:0] trl = TRL_BYTE);
        send_byte(HDR_BYTE, h); send_byte(8'($urandom_range(0, 255)), h);
        send_byte(x[7:0], h); send_byte(x[15:8], h);
        send_byte(y[7:0], h); send_byte(y[15:8], h);
        send_byte(t, h); send_byte(q, h); send_byte(trl, h);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            oft_pkg::REG_FRESH_WINDOW: fresh_win = val;
            oft_pkg::REG_QUAL_THRESH:  q_thresh = val[7:0];
            oft_pkg::REG_DECAY_TMO:    decay_tmo = val;
            oft_pkg::REG_HEIGHT_OFS:   h_ofs = val[11:0];
            default: ;
        endcase
    endtask

    // Receiver stall bursts
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk) begin
        track_res_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result item with none expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (event_res !== e.ev) begin
                    $error("event_res exp %0d got %0d", e.ev, event_res); errors++; end
                if (vel_x !== e.vx) begin
                    $error("vel_x exp %0d got %0d", e.vx, vel_x); errors++; end
                if (vel_y !== e.vy) begin
                    $error("vel_y exp %0d got %0d", e.vy, vel_y); errors++; end
                if (pos_x !== e.px) begin
                    $error("pos_x exp %h got %h", e.px, pos_x); errors++; end
                if (pos_y !== e.py) begin
                    $error("pos_y exp %h got %h", e.py, pos_y); errors++; end
                if (quality !== e.q) begin
                    $error("quality exp %0d got %0d", e.q, quality); errors++; end
                if (quality_sum !== e.qsum) begin
                    $error("quality_sum exp %0d got %0d", e.qsum, quality_sum); errors++; end
                if (sample_count !== e.cnt) begin
                    $error("sample_count exp %0d got %0d", e.cnt, sample_count); errors++; end
                if (window_sum_x !== e.wsx) begin
                    $error("window_sum_x exp %h got %h", e.wsx, window_sum_x); errors++; end
                if (window_sum_y !== e.wsy) begin
                    $error("window_sum_y exp %h got %h", e.wsy, window_sum_y); errors++; end
                if (raw_t !== e.t) begin
                    $error("raw_t exp %0d got %0d", e.t, raw_t); errors++; end
            end
        end
    end

    // Field extremes, t folding, bad header and trailer, offset clamp
    task automatic test_directed();
        send_byte(8'h00);
        send_frame(16'h7FFF, 16'h8000, 8'd255, 8'd255, 12'd4095);
        send_frame(16'h8000, 16'h7FFF, 8'd128, 8'd0, 12'd10);
        send_frame(16'hFFFF, 16'h0001, 8'd127, 8'd200, 12'd300, 8'h55);
    endtask

    // Decay: idle long enough and not long enough, then a run of decays
    task automatic test_decay();
        clock_us = clock_us + 32'd100000;
        send_item(OP_TIME, 8'hFF, clock_us, 12'hFFF);
        send_item(OP_TIME, 8'h00, clock_us + 32'd10, 12'd0);
        drain();
        write_reg(oft_pkg::REG_DECAY_TMO, 32'd0);
        for (int i = 0; i < 60; i++) begin
            clock_us = clock_us + 32'd1;
            send_item(OP_TIME, 8'd0, clock_us, 12'd0);
        end
        drain();
    endtask

    // Register sweeps including extremes
    task automatic test_config();
        logic [31:0] w[3] = '{32'd0, 32'hFFFF_FFFF, 32'd2000};
        for (int k = 0; k < 3; k++) begin
            drain();
            write_reg(oft_pkg::REG_FRESH_WINDOW, w[k]);
            write_reg(oft_pkg::REG_QUAL_THRESH,
                      (k == 0) ? 32'd0 : (k == 1) ? 32'hFF : 32'd70);
            write_reg(oft_pkg::REG_DECAY_TMO, w[2 - k]);
            write_reg(oft_pkg::REG_HEIGHT_OFS, (k == 1) ? 32'hFFF : 32'(k * 40));
            for (int i = 0; i < 3; i++)
                send_frame(16'($urandom), 16'($urandom), 8'($urandom),
                           8'($urandom), 12'($urandom));
            clock_us = clock_us + 32'd60000;
            send_item(OP_TIME, 8'd0, clock_us, 12'd0);
        end
        drain();
        write_reg(oft_pkg::REG_FRESH_WINDOW, 32'd50000);
        write_reg(oft_pkg::REG_QUAL_THRESH, 32'd70);
        write_reg(oft_pkg::REG_DECAY_TMO, 32'd20000);
        write_reg(oft_pkg::REG_HEIGHT_OFS, 32'd40);
    endtask

    // Mostly good frames with random content, plus noise, time checks and broken frames
    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_byte(8'($urandom));
                    sent++;
                end
                1: begin
                    clock_us = clock_us + $urandom_range(0, 80000);
                    send_item(OP_TIME, 8'($urandom), clock_us, 12'($urandom));
                    sent++;
                end
                2: begin
                    send_frame(16'($urandom), 16'($urandom), 8'($urandom),
                               8'($urandom), 12'($urandom), 8'($urandom));
                    sent += 9;
                end
                3: begin
                    clock_us = $urandom;
                    send_frame(16'($urandom), 16'($urandom), 8'($urandom),
                               8'($urandom), 12'($urandom));
                    sent += 9;
                end
                default: begin
                    send_frame(16'($urandom), 16'($urandom), 8'($urandom),
                               8'($urandom_range(60, 255)), 12'($urandom));
                    sent += 9;
                end
            endcase
        end
    endtask

    initial begin
        tracker_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_config();
        test_decay();
        test_random(850);
        no_idle = 1;
        test_random(300);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("optical_flow_frame_tracker_top verification clean");
        else
            $display("optical_flow_frame_tracker_top verification failed");
        $finish;
    end
endmodule
